// ===== rtl/cqsc_pkg.sv =====
`default_nettype none

package cqsc_pkg;

  // default build sizes
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_NUM_QUEUES  = 4;

  // field widths
  localparam int CMD_W  = 2;
  localparam int SEL_W  = 2;
  localparam int WORD_W = 32;
  localparam int CAP_W  = 5;
  localparam int STAT_W = 2;

  // stream data widths, padded to whole bytes
  localparam int IN_FIELDS_W  = CMD_W + SEL_W + SEL_W + WORD_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_PAD_W     = IN_TDATA_W - IN_FIELDS_W;
  localparam int OUT_FIELDS_W = STAT_W + WORD_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_CMP = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/cqsc_ram.sv =====
`default_nettype none

module cqsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== rtl/circular_queue_set_with_compare.sv =====
// channel  dir  handshake                fields
// in_      in   in_tvalid / in_tready    cmd, queue_sel, other_sel, push_value
// out_     out  out_tvalid / out_tready  status, pop_value, identical
// cfg_     in   cfg_valid / cfg_ready    queue_capacity
//
// commands pass load_a, load_b, op and fin; dequeue of a non-empty queue adds a pop
// state, and compare adds walk and drain states unless counts differ or both are empty;
// the walk reads one entry of each ring per cycle through both read ports of the ram.
// one command is in flight at a time; in_tready is high only while the sequencer idles.
// a finished result waits in the output register while the next command is taken.
// reset: all queues empty, capacity at full depth, no clearing pass.
`default_nettype none

module circular_queue_set_with_compare #(
  parameter int QUEUE_DEPTH = cqsc_pkg::DEF_QUEUE_DEPTH,
  parameter int NUM_QUEUES  = cqsc_pkg::DEF_NUM_QUEUES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [1:0] cmd, [3:2] queue_sel, [5:4] other_sel, [37:6] push_value, rest zero
  input  wire logic [cqsc_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [1:0] status, [33:2] pop_value, [34] identical, rest zero
  output logic      [cqsc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cqsc_pkg::CAP_W-1:0]       cfg_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int QW = $clog2(NUM_QUEUES);
  localparam int RAM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW = $clog2(RAM_DEPTH);
  localparam int WW = cqsc_pkg::WORD_W;
  localparam int SW = cqsc_pkg::SEL_W;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD_A, S_LOAD_B, S_OP, S_POP, S_WALK, S_DRAIN, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  cqsc_pkg::cmd_t cmd_r, cmd_nxt;
  logic [SW-1:0] qa_r, qa_nxt, qb_r, qb_nxt;
  logic [WW-1:0] word_r, word_nxt;
  logic [PW-1:0] ha_r, ha_nxt, hb_r, hb_nxt, pa_r, pa_nxt, pb_r, pb_nxt;
  logic [CW-1:0] ca_r, ca_nxt, cb_r, cb_nxt, left_r, left_nxt;
  logic cmpv_r, cmpv_nxt, miss_r, miss_nxt;
  logic [cqsc_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [WW-1:0] res_pop_r, res_pop_nxt;
  logic res_same_r, res_same_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [cqsc_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [CW-1:0] cap_r, cap_nxt;
  logic [PW-1:0] head_r [NUM_QUEUES];
  logic [PW-1:0] head_nxt [NUM_QUEUES];
  logic [CW-1:0] cnt_r [NUM_QUEUES];
  logic [CW-1:0] cnt_nxt [NUM_QUEUES];

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [WW-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

  logic [SW-1:0] sel_q;
  logic sel_ok, qa_ok, qb_ok;
  logic [PW-1:0] rd_head;
  logic [CW-1:0] rd_cnt;
  logic [31:0] cfg_ext;

  // position after stepping on by inc, wrapped at the capacity (stays below 2*cap)
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] pos,
                                             input logic [CW-1:0] inc,
                                             input logic [CW-1:0] cap);
    logic [CW:0] sum;
    sum = (CW+1)'(pos) + (CW+1)'(inc);
    if (sum >= (CW+1)'(cap)) begin
      sum = sum - (CW+1)'(cap);
    end
    return PW'(sum);
  endfunction

  function automatic logic [AW-1:0] ram_addr(input logic [SW-1:0] q,
                                             input logic [PW-1:0] pos);
    logic [31:0] a;
    a = 32'(q) * 32'(QUEUE_DEPTH) + 32'(pos);
    return AW'(a);
  endfunction

  cqsc_ram #(
    .WIDTH (WW),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign qa_ok = (32'(qa_r) < 32'(NUM_QUEUES));
  assign qb_ok = (32'(qb_r) < 32'(NUM_QUEUES));

  // one read of the pointer tables per cycle: first queue, then second
  assign sel_q   = (state_r == S_LOAD_B) ? qb_r : qa_r;
  assign sel_ok  = (32'(sel_q) < 32'(NUM_QUEUES));
  assign rd_head = sel_ok ? head_r[QW'(sel_q)] : '0;
  assign rd_cnt  = sel_ok ? cnt_r[QW'(sel_q)] : '0;
  assign cfg_ext = 32'(cfg_data);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    qa_nxt         = qa_r;
    qb_nxt         = qb_r;
    word_nxt       = word_r;
    ha_nxt         = ha_r;
    hb_nxt         = hb_r;
    ca_nxt         = ca_r;
    cb_nxt         = cb_r;
    pa_nxt         = pa_r;
    pb_nxt         = pb_r;
    left_nxt       = left_r;
    cmpv_nxt       = cmpv_r;
    miss_nxt       = miss_r;
    res_status_nxt = res_status_r;
    res_pop_nxt    = res_pop_r;
    res_same_nxt   = res_same_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    cap_nxt        = cap_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = ram_addr(qa_r, wrap_add(ha_r, ca_r, cap_r));
    ram_wdata      = word_r;
    ram_raddr_a    = ram_addr(qa_r, pa_r);
    ram_raddr_b    = ram_addr(qb_r, pb_r);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = cqsc_pkg::cmd_t'(in_tdata[1:0]);
          qa_nxt    = in_tdata[3:2];
          qb_nxt    = in_tdata[5:4];
          word_nxt  = in_tdata[37:6];
          state_nxt = S_LOAD_A;
        end
      end
      S_LOAD_A: begin
        ha_nxt    = rd_head;
        ca_nxt    = rd_cnt;
        state_nxt = S_LOAD_B;
      end
      S_LOAD_B: begin
        hb_nxt    = rd_head;
        cb_nxt    = rd_cnt;
        state_nxt = S_OP;
      end
      S_OP: begin
        res_status_nxt = cqsc_pkg::ST_DONE;
        res_pop_nxt    = '0;
        res_same_nxt   = 1'b0;
        state_nxt      = S_FIN;
        case (cmd_r)
          cqsc_pkg::CMD_ENQ: begin
            if (qa_ok) begin
              if (ca_r >= cap_r) begin
                res_status_nxt = cqsc_pkg::ST_FULL;
              end else begin
                ram_we                = 1'b1;
                cnt_nxt[QW'(qa_r)]    = ca_r + CW'(1);
              end
            end
          end
          cqsc_pkg::CMD_DEQ: begin
            if (qa_ok) begin
              if (ca_r == '0) begin
                res_status_nxt = cqsc_pkg::ST_EMPTY;
                res_pop_nxt    = '1;
              end else begin
                ram_raddr_a        = ram_addr(qa_r, ha_r);
                head_nxt[QW'(qa_r)] = wrap_add(ha_r, CW'(1), cap_r);
                cnt_nxt[QW'(qa_r)]  = ca_r - CW'(1);
                state_nxt          = S_POP;
              end
            end
          end
          cqsc_pkg::CMD_CMP: begin
            if (qa_ok && qb_ok) begin
              if (ca_r != cb_r) begin
                res_same_nxt = 1'b0;
              end else if (ca_r == '0) begin
                res_same_nxt = 1'b1;
              end else begin
                pa_nxt    = ha_r;
                pb_nxt    = hb_r;
                left_nxt  = ca_r;
                cmpv_nxt  = 1'b0;
                miss_nxt  = 1'b0;
                state_nxt = S_WALK;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        res_pop_nxt = ram_rdata_a;
        state_nxt   = S_FIN;
      end
      S_WALK: begin
        // issue one pair of reads and check the previous pair, which the ram now returns
        if (cmpv_r && (ram_rdata_a != ram_rdata_b)) begin
          miss_nxt = 1'b1;
        end
        pa_nxt   = wrap_add(pa_r, CW'(1), cap_r);
        pb_nxt   = wrap_add(pb_r, CW'(1), cap_r);
        left_nxt = left_r - CW'(1);
        cmpv_nxt = 1'b1;
        if (left_r == CW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        res_same_nxt = !(miss_r || (ram_rdata_a != ram_rdata_b));
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{cqsc_pkg::OUT_PAD_W{1'b0}}, res_same_r, res_pop_r, res_status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // capacity write empties every queue
    if (cfg_valid) begin
      if (cfg_ext == 32'd0) begin
        cap_nxt = CW'(1);
      end else if (cfg_ext > 32'(QUEUE_DEPTH)) begin
        cap_nxt = CW'(QUEUE_DEPTH);
      end else begin
        cap_nxt = CW'(cfg_ext);
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_nxt[i] = '0;
        cnt_nxt[i]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cap_r       <= CW'(QUEUE_DEPTH);
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      cmd_r        <= cmd_nxt;
      qa_r         <= qa_nxt;
      qb_r         <= qb_nxt;
      word_r       <= word_nxt;
      ha_r         <= ha_nxt;
      hb_r         <= hb_nxt;
      ca_r         <= ca_nxt;
      cb_r         <= cb_nxt;
      pa_r         <= pa_nxt;
      pb_r         <= pb_nxt;
      left_r       <= left_nxt;
      cmpv_r       <= cmpv_nxt;
      miss_r       <= miss_nxt;
      res_status_r <= res_status_nxt;
      res_pop_r    <= res_pop_nxt;
      res_same_r   <= res_same_nxt;
      out_valid_r  <= out_valid_nxt;
      out_data_r   <= out_data_nxt;
      cap_r        <= cap_nxt;
      head_r       <= head_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== test/queue_set_checker.sv =====
`timescale 1ns / 100ps

module queue_set_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  input  logic [cqsc_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic [cqsc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [cqsc_pkg::CAP_W-1:0]           cfg_data,
  output int                                   errors,
  output int                                   pending,
  output int                                   checked,
  output int                                   matching_compares,
  output int                                   full_drops,
  output int                                   empty_pops
);

  localparam int DEPTH  = cqsc_pkg::DEF_QUEUE_DEPTH;
  localparam int NQ     = cqsc_pkg::DEF_NUM_QUEUES;
  localparam int CMDW   = cqsc_pkg::CMD_W;
  localparam int SW     = cqsc_pkg::SEL_W;
  localparam int WW     = cqsc_pkg::WORD_W;
  localparam int STW    = cqsc_pkg::STAT_W;

  typedef struct packed {
    logic [STW-1:0]       status;
    logic signed [WW-1:0] pop_value;
    logic                 identical;
  } answer_t;

  logic [WW-1:0]     ring_words [NQ][DEPTH];
  int unsigned       ring_head  [NQ];
  int unsigned       ring_count [NQ];
  int unsigned       ring_cap = DEPTH;
  answer_t           expected_answers [$];
  int                n_err, n_checked, n_match, n_full, n_empty;

  function automatic int unsigned wrap(input int unsigned pos);
    return (pos >= ring_cap) ? pos - ring_cap : pos;
  endfunction

  task automatic clear_queues();
    foreach (ring_head[q]) begin
      ring_head[q]  = 0;
      ring_count[q] = 0;
    end
  endtask

  // updates the queue set and returns the answer the block owes for this command
  function automatic answer_t apply_command(input cqsc_pkg::cmd_t op, input int unsigned qa,
                                            input int unsigned qb,
                                            input logic [WW-1:0] word);
    answer_t     a;
    int unsigned pa, pb, k;
    logic        same;
    a = '0;
    a.status = cqsc_pkg::ST_DONE;
    case (op)
      cqsc_pkg::CMD_ENQ: begin
        if (ring_count[qa] >= ring_cap) begin
          a.status = cqsc_pkg::ST_FULL;
          n_full++;
        end else begin
          ring_words[qa][wrap(ring_head[qa] + ring_count[qa])] = word;
          ring_count[qa]++;
        end
      end
      cqsc_pkg::CMD_DEQ: begin
        if (ring_count[qa] == 0) begin
          a.status    = cqsc_pkg::ST_EMPTY;
          a.pop_value = '1;
          n_empty++;
        end else begin
          a.pop_value   = ring_words[qa][ring_head[qa]];
          ring_head[qa] = wrap(ring_head[qa] + 1);
          ring_count[qa]--;
        end
      end
      cqsc_pkg::CMD_CMP: begin
        same = (ring_count[qa] == ring_count[qb]);
        pa   = ring_head[qa];
        pb   = ring_head[qb];
        for (k = 0; same && k < ring_count[qa]; k++) begin
          if (ring_words[qa][pa] != ring_words[qb][pb])
            same = 1'b0;
          pa = wrap(pa + 1);
          pb = wrap(pb + 1);
        end
        a.identical = same;
        if (same)
          n_match++;
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin : watch
    answer_t want, seen;
    if (!rst_n) begin
      clear_queues();
      ring_cap = DEPTH;
      expected_answers.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        // out-of-range capacities are clamped, and every write empties the set
        if (cfg_data == 0)
          ring_cap = 1;
        else if (cfg_data > DEPTH)
          ring_cap = DEPTH;
        else
          ring_cap = 32'(cfg_data);
        clear_queues();
      end
      if (in_tvalid && in_tready)
        expected_answers.push_back(apply_command(cqsc_pkg::cmd_t'(in_tdata[CMDW-1:0]),
                                                 32'(in_tdata[CMDW +: SW]),
                                                 32'(in_tdata[CMDW+SW +: SW]),
                                                 in_tdata[CMDW+2*SW +: WW]));
      if (out_tvalid && out_tready) begin
        seen.status    = out_tdata[STW-1:0];
        seen.pop_value = out_tdata[STW +: WW];
        seen.identical = out_tdata[STW+WW];
        if (expected_answers.size() == 0) begin
          n_err++;
          $display("%0t: result %h arrived with no command outstanding", $time, out_tdata);
        end else begin
          want = expected_answers.pop_front();
          n_checked++;
          if (seen.status !== want.status) begin
            n_err++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, seen.status);
          end
          if (seen.pop_value !== want.pop_value) begin
            n_err++;
            $display("%0t: pop_value mismatch, expected %0d, got %0d",
                     $time, $signed(want.pop_value), $signed(seen.pop_value));
          end
          if (seen.identical !== want.identical) begin
            n_err++;
            $display("%0t: identical mismatch, expected %0b, got %0b",
                     $time, want.identical, seen.identical);
          end
        end
      end
    end
    errors            <= n_err;
    pending           <= expected_answers.size();
    checked           <= n_checked;
    matching_compares <= n_match;
    full_drops        <= n_full;
    empty_pops        <= n_empty;
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH       = cqsc_pkg::DEF_QUEUE_DEPTH;
  localparam int PHASE_ITEMS = 137;
  localparam int SW          = cqsc_pkg::SEL_W;
  localparam int WW          = cqsc_pkg::WORD_W;
  localparam int CAPW        = cqsc_pkg::CAP_W;

  logic                                 clk = 1'b0;
  logic                                 rst_n;
  logic                                 in_tvalid;
  logic                                 in_tready;
  // [1:0] cmd, [3:2] queue_sel, [5:4] other_sel, [37:6] push_value, rest zero
  logic [cqsc_pkg::IN_TDATA_W-1:0]      in_tdata;
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b0;
  // [1:0] status, [33:2] pop_value, [34] identical, rest zero
  logic [cqsc_pkg::OUT_TDATA_W-1:0]     out_tdata;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [CAPW-1:0]                      cfg_data;

  int fail_count, pending, checked, matching_compares, full_drops, empty_pops;
  int items_sent = 0;
  int burst_left = 0;
  int rx_cycle   = 0;
  int rx_mode    = 0;
  int hold_left  = 0;
  int long_holds = 0;
  logic rx_ready_next;

  always #5 clk = ~clk;

  circular_queue_set_with_compare DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  queue_set_checker answer_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .errors            (fail_count),
    .pending           (pending),
    .checked           (checked),
    .matching_compares (matching_compares),
    .full_drops        (full_drops),
    .empty_pops        (empty_pops)
  );

  // receiver: changing ready patterns, with occasional long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_ready_next = 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        rx_ready_next = 1'b0;
      end else if (rx_cycle == 2500 || $urandom_range(0, 4999) == 0) begin
        hold_left     = $urandom_range(150, 300);
        rx_ready_next = 1'b0;
        long_holds++;
      end else begin
        if (rx_cycle % 97 == 0)
          rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0:       rx_ready_next = 1'b1;
          1:       rx_ready_next = ($urandom_range(0, 3) != 0);
          2:       rx_ready_next = ($urandom_range(0, 3) == 0);
          default: rx_ready_next = ((rx_cycle % 5) < 2);
        endcase
      end
    end
    out_tready <= rx_ready_next;
  end

  function automatic logic [WW-1:0] pick_word();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return '1;
          default: return '0;
        endcase
      end
      default: return $urandom_range(0, 7);
    endcase
  endfunction

  // one command transaction, sent in bursts with random gaps between them
  task automatic offer(input cqsc_pkg::cmd_t op, input logic [SW-1:0] qa,
                       input logic [SW-1:0] qb, input logic [WW-1:0] word);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tdata  <= {{cqsc_pkg::IN_PAD_W{1'b0}}, word, qb, qa, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // only written with the block idle: nothing outstanding, input quiet
  task automatic set_capacity(input logic [CAPW-1:0] value);
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // twin queues get mirrored traffic so that compares can match deep into the rings
  task automatic run_traffic(input int n, input int span);
    int          start, r;
    logic [SW-1:0] ta, tb;
    logic [WW-1:0] w;
    start = items_sent;
    ta    = SW'($urandom_range(0, 3));
    tb    = ta + SW'($urandom_range(1, 3));
    while (items_sent - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        w = pick_word();
        offer(cqsc_pkg::CMD_ENQ, ta, SW'($urandom()), w);
        offer(cqsc_pkg::CMD_ENQ, tb, SW'($urandom()), w);
      end else if (r < 52) begin
        offer(cqsc_pkg::CMD_DEQ, ta, SW'($urandom()), $urandom());
        offer(cqsc_pkg::CMD_DEQ, tb, SW'($urandom()), $urandom());
      end else if (r < 66) begin
        if ($urandom_range(0, 1) == 0)
          offer(cqsc_pkg::CMD_CMP, ta, tb, $urandom());
        else
          offer(cqsc_pkg::CMD_CMP, tb, ta, $urandom());
      end else if (r < 69) begin
        if (r == 68) begin
          ta = SW'($urandom_range(0, 3));
          tb = ($urandom_range(0, 9) == 0) ? ta : ta + SW'($urandom_range(1, 3));
        end
        // drain both twins so they line up again
        repeat (span) begin
          offer(cqsc_pkg::CMD_DEQ, ta, SW'($urandom()), $urandom());
          offer(cqsc_pkg::CMD_DEQ, tb, SW'($urandom()), $urandom());
        end
      end else begin
        offer(cqsc_pkg::cmd_t'($urandom_range(0, 3)), SW'($urandom_range(0, 3)),
              SW'($urandom_range(0, 3)), pick_word());
      end
    end
  endtask

  initial begin : stimulus
    logic [CAPW-1:0] caps [9];
    int              span;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset capacity
    offer(cqsc_pkg::CMD_ENQ, 2'd0, 2'd3, 32'h8000_0000);
    offer(cqsc_pkg::CMD_ENQ, 2'd0, 2'd0, 32'h7FFF_FFFF);
    offer(cqsc_pkg::CMD_ENQ, 2'd0, 2'd1, 32'hFFFF_FFFF);
    offer(cqsc_pkg::CMD_ENQ, 2'd0, 2'd2, 32'h0000_0000);
    offer(cqsc_pkg::CMD_CMP, 2'd0, 2'd1, 32'hFFFF_FFFF);   // counts differ
    offer(cqsc_pkg::CMD_CMP, 2'd0, 2'd0, 32'h0000_0000);   // queue against itself
    offer(cqsc_pkg::CMD_CMP, 2'd1, 2'd1, 32'h5555_5555);   // both empty
    offer(cqsc_pkg::CMD_DEQ, 2'd1, 2'd3, 32'hAAAA_AAAA);   // empty queue
    offer(cqsc_pkg::CMD_NOP, 2'd3, 2'd2, 32'hFFFF_FFFF);
    offer(cqsc_pkg::CMD_NOP, 2'd0, 2'd1, 32'h0000_0000);
    offer(cqsc_pkg::CMD_ENQ, 2'd1, 2'd0, 32'h8000_0000);
    offer(cqsc_pkg::CMD_ENQ, 2'd1, 2'd0, 32'h7FFF_FFFF);
    offer(cqsc_pkg::CMD_ENQ, 2'd1, 2'd0, 32'hFFFF_FFFF);
    offer(cqsc_pkg::CMD_ENQ, 2'd1, 2'd0, 32'h0000_0000);
    offer(cqsc_pkg::CMD_CMP, 2'd1, 2'd0, 32'h1234_5678);   // same words in order
    offer(cqsc_pkg::CMD_ENQ, 2'd2, 2'd3, 32'h8000_0000);
    offer(cqsc_pkg::CMD_ENQ, 2'd2, 2'd3, 32'h7FFF_FFFF);
    offer(cqsc_pkg::CMD_ENQ, 2'd2, 2'd3, 32'h0000_0000);
    offer(cqsc_pkg::CMD_ENQ, 2'd2, 2'd3, 32'hFFFF_FFFF);
    offer(cqsc_pkg::CMD_CMP, 2'd0, 2'd2, 32'h0000_0000);   // same count, order differs
    offer(cqsc_pkg::CMD_DEQ, 2'd0, 2'd2, 32'h0000_0000);
    offer(cqsc_pkg::CMD_DEQ, 2'd3, 2'd1, 32'hFFFF_FFFF);

    caps = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd3, 5'd5, 5'd16, 5'd1};
    caps[8] = CAPW'($urandom_range(1, DEPTH));
    foreach (caps[i]) begin
      set_capacity(caps[i]);
      span = (caps[i] == 0) ? 1 : (caps[i] > DEPTH) ? DEPTH : int'(caps[i]);
      run_traffic(PHASE_ITEMS, span + 1);
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
    $display("%0d commands at capacities 1, 0, 31, 17, 2, 3, 5, 16 and %0d; %0d long hold-offs",
             items_sent, caps[8], long_holds);
    $display("%0d results checked: %0d matching compares, %0d full drops, %0d empty pops",
             checked, matching_compares, full_drops, empty_pops);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== circular_queue_set_with_compare.f =====
rtl/cqsc_pkg.sv
rtl/cqsc_ram.sv
rtl/circular_queue_set_with_compare.sv
test/queue_set_checker.sv
test/testbench.sv
